// ===== hdl/palette_floyd_steinberg_dither_assert.svh =====
// Assertion macros for the palette dither block.
`ifndef PALETTE_FLOYD_STEINBERG_DITHER_ASSERT_SVH
`define PALETTE_FLOYD_STEINBERG_DITHER_ASSERT_SVH

// Same-cycle implication.
`define PFSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfsd assertion failed");

// Next-cycle implication.
`define PFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfsd assertion failed");

`endif

// ===== hdl/pfsd_pkg.sv =====
// Package: widths, register indexes, states and helpers of the palette dither block.
`timescale 1ns / 1ps
`default_nettype none
package pfsd_pkg;
   localparam int PIX_W = 8;
   localparam int ERR_W = 11;
   localparam int SHR_W = 12;
   localparam int CH_N = 3;
   localparam int CPC_W = 3;
   localparam int CSR_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int INDEX_W = 8;
   localparam int INDEX_MAX = 215;
   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_COLORS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DITHER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd2;

   localparam logic [CPC_W-1:0] CPC_RESET = 3'd6;
   localparam logic [CSR_W-1:0] WIDTH_RESET = 11'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUANT,
      ST_ERROR,
      ST_WR_A,
      ST_WR_B,
      ST_WR_C
   } state_type;

   // 255 / m for m = 1..5
   function automatic logic [PIX_W-1:0] step_of(input logic [CPC_W-1:0] m);
      logic [PIX_W-1:0] s;
      begin
         case (m)
            3'd1: s = 8'd255;
            3'd2: s = 8'd127;
            3'd3: s = 8'd85;
            3'd4: s = 8'd63;
            3'd5: s = 8'd51;
            default: s = 8'd255;
         endcase
         return s;
      end
   endfunction

   function automatic logic signed [ERR_W-1:0] sat_add(input logic signed [ERR_W-1:0] a,
                                                       input logic signed [SHR_W-1:0] b);
      logic signed [ERR_W+1:0] s;
      begin
         s = $signed({{2{a[ERR_W-1]}}, a}) + $signed({b[SHR_W-1], b});
         if (s > 13'sd1023) return 11'sd1023;
         if (s < -13'sd1024) return -11'sd1024;
         return s[ERR_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/pfsd_if.sv =====
// Channel interfaces: pixel request and palette index response.
`timescale 1ns / 1ps
`default_nettype none
interface pfsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfsd_pkg::PIX_W-1:0]  red_in;
   logic [pfsd_pkg::PIX_W-1:0]  green_in;
   logic [pfsd_pkg::PIX_W-1:0]  blue_in;
   logic                        frame_start;
   modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
   modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface pfsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfsd_pkg::INDEX_W-1:0]  palette_index;
   modport source (output valid, palette_index, input ready);
   modport sink (input valid, palette_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/palette_floyd_steinberg_dither.sv =====
// Palette dither top level: raster RGB in, one palette index per pixel out.
//
// req_channel takes one pixel per beat (red, green, blue, frame_start);
// rsp_channel returns one palette_index beat per pixel, in order.
// csr_* writes the color levels, dither_enable and image_width; write only
// while no pixel is in flight.
// Each pixel runs from accept to the next accept through one read of the
// current-row error, quantize, error and result, then three read-modify-write
// passes on the single write port of the next-row error memory.
// The result beat is registered in the result step, after quantize. It sits in an output
// register, so the next pixel is taken while it waits; a stalled receiver holds
// the block in the result step only when a second result is ready to go.
// Two error memories swap roles at every row end; a fill count per memory
// marks the written prefix, so no clearing pass is run. Reset is
// synchronous: registers go to 6 colors, dither on, width 64, both memories
// read as zero, column 0. frame_start empties both memories at once.
`timescale 1ns / 1ps
`default_nettype none
module palette_floyd_steinberg_dither #(
   parameter int MAX_WIDTH = pfsd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   pfsd_req_if.sink                           req_channel,
   pfsd_rsp_if.source                         rsp_channel,
   input  wire                                csr_write_enable,
   input  wire [pfsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [pfsd_pkg::CSR_W-1:0]          csr_write_data
);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = pfsd_pkg::ERR_W;
   localparam int DW = pfsd_pkg::CH_N * EW;

   pfsd_pkg::state_type state_ff, state_in;

   logic [pfsd_pkg::CPC_W-1:0] cpc_ff;
   logic                       dither_ff;
   logic [pfsd_pkg::CSR_W-1:0] width_ff;

   logic [AW-1:0] col_ff, col_in;
   logic          sel_ff, sel_in;
   logic [WW-1:0] fill_cur_ff, fill_cur_in, fill_nxt_ff, fill_nxt_in;
   logic [AW-1:0] x_ff;
   logic          last_ff, right_ff;
   logic [pfsd_pkg::PIX_W-1:0] pix_ff [pfsd_pkg::CH_N];
   logic [pfsd_pkg::PIX_W-1:0] v_ff [pfsd_pkg::CH_N];
   logic [pfsd_pkg::CPC_W-1:0] q_ff [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh7_ff [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh5_ff [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh3_ff [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh1_ff [pfsd_pkg::CH_N];
   logic                          out_valid_ff;
   logic [pfsd_pkg::INDEX_W-1:0]  out_index_ff;
   logic                          cur_vld_ff, nxt_vld_ff;

   logic [DW-1:0] bank0 [MAX_WIDTH];
   logic [DW-1:0] bank1 [MAX_WIDTH];
   logic [DW-1:0] bank0_q_ff, bank1_q_ff;

   logic [pfsd_pkg::CPC_W-1:0] cpc_eff, m_eff;
   logic [pfsd_pkg::PIX_W-1:0] step;
   logic [WW-1:0]              w_eff;
   logic                       accept, out_load;
   logic [AW-1:0]              x_acc, x_p1, x_m1;
   logic [DW-1:0]              cur_q, nxt_q;
   logic [AW-1:0]              cur_ra, nxt_ra, cur_wa, nxt_wa;
   logic                       cur_we, nxt_we, cur_rd_vld, nxt_rd_vld;
   logic [DW-1:0]              cur_wd, nxt_wd;
   logic [WW-1:0]              fill_cur_wr, fill_nxt_wr;
   logic [pfsd_pkg::PIX_W-1:0] v_calc [pfsd_pkg::CH_N];
   logic [pfsd_pkg::CPC_W-1:0] q_calc [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh7_c [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh5_c [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh3_c [pfsd_pkg::CH_N];
   logic signed [pfsd_pkg::SHR_W-1:0] sh1_c [pfsd_pkg::CH_N];
   logic [pfsd_pkg::INDEX_W-1:0]  index_c;

   // settings, clamped
   always_comb begin
      if (cpc_ff < 3'd2) cpc_eff = 3'd2;
      else if (cpc_ff > 3'd6) cpc_eff = 3'd6;
      else cpc_eff = cpc_ff;
      m_eff = cpc_eff - 3'd1;
      step = pfsd_pkg::step_of(m_eff);
      if (width_ff == '0) w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
   end

   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = (state_ff == pfsd_pkg::ST_IDLE);
   assign out_load = !out_valid_ff || rsp_channel.ready;
   assign rsp_channel.valid = out_valid_ff;
   assign rsp_channel.palette_index = out_index_ff;

   assign x_acc = (req_channel.frame_start || WW'(col_ff) >= w_eff) ? '0 : col_ff;
   assign x_p1 = x_ff + AW'(1);
   assign x_m1 = x_ff - AW'(1);
   assign cur_q = sel_ff ? bank1_q_ff : bank0_q_ff;
   assign nxt_q = sel_ff ? bank0_q_ff : bank1_q_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfsd_pkg::ST_IDLE:  if (accept) state_in = pfsd_pkg::ST_QUANT;
         pfsd_pkg::ST_QUANT: state_in = pfsd_pkg::ST_ERROR;
         pfsd_pkg::ST_ERROR: if (out_load) state_in = pfsd_pkg::ST_WR_A;
         pfsd_pkg::ST_WR_A:  state_in = pfsd_pkg::ST_WR_B;
         pfsd_pkg::ST_WR_B:  state_in = pfsd_pkg::ST_WR_C;
         pfsd_pkg::ST_WR_C:  state_in = pfsd_pkg::ST_IDLE;
         default:            state_in = pfsd_pkg::ST_IDLE;
      endcase
   end

   // memory controls; an unwritten current-row entry is written as zero to keep the prefix whole
   always_comb begin
      cur_ra = x_p1;
      nxt_ra = x_m1;
      cur_we = 1'b0;
      nxt_we = 1'b0;
      cur_wa = x_ff;
      nxt_wa = x_ff;
      cur_wd = '0;
      nxt_wd = '0;
      cur_rd_vld = WW'(x_p1) < fill_cur_ff;
      nxt_rd_vld = WW'(x_m1) < fill_nxt_ff;
      case (state_ff)
         pfsd_pkg::ST_IDLE: begin
            cur_ra = x_acc;
            cur_rd_vld = !req_channel.frame_start && (WW'(x_acc) < fill_cur_ff);
         end
         pfsd_pkg::ST_QUANT: begin
            cur_we = !cur_vld_ff;
         end
         pfsd_pkg::ST_ERROR: begin
         end
         pfsd_pkg::ST_WR_A: begin
            nxt_ra = x_ff;
            nxt_rd_vld = WW'(x_ff) < fill_nxt_ff;
            cur_we = right_ff;
            cur_wa = x_p1;
            nxt_we = (x_ff != '0);
            nxt_wa = x_m1;
            for (int c = 0; c < pfsd_pkg::CH_N; c++) begin
               cur_wd[c*EW +: EW] = pfsd_pkg::sat_add(
                  cur_vld_ff ? $signed(cur_q[c*EW +: EW]) : '0, sh7_ff[c]);
               nxt_wd[c*EW +: EW] = pfsd_pkg::sat_add(
                  nxt_vld_ff ? $signed(nxt_q[c*EW +: EW]) : '0, sh3_ff[c]);
            end
         end
         pfsd_pkg::ST_WR_B: begin
            nxt_ra = x_p1;
            nxt_rd_vld = WW'(x_p1) < fill_nxt_ff;
            nxt_we = 1'b1;
            nxt_wa = x_ff;
            for (int c = 0; c < pfsd_pkg::CH_N; c++)
               nxt_wd[c*EW +: EW] = pfsd_pkg::sat_add(
                  nxt_vld_ff ? $signed(nxt_q[c*EW +: EW]) : '0, sh5_ff[c]);
         end
         pfsd_pkg::ST_WR_C: begin
            nxt_we = right_ff;
            nxt_wa = x_p1;
            for (int c = 0; c < pfsd_pkg::CH_N; c++)
               nxt_wd[c*EW +: EW] = pfsd_pkg::sat_add(
                  nxt_vld_ff ? $signed(nxt_q[c*EW +: EW]) : '0, sh1_ff[c]);
         end
         default: begin
         end
      endcase
   end

   // written prefix lengths
   always_comb begin
      fill_cur_wr = fill_cur_ff;
      fill_nxt_wr = fill_nxt_ff;
      if (cur_we && WW'(cur_wa) >= fill_cur_ff) fill_cur_wr = WW'(cur_wa) + WW'(1);
      if (nxt_we && WW'(nxt_wa) >= fill_nxt_ff) fill_nxt_wr = WW'(nxt_wa) + WW'(1);
      fill_cur_in = fill_cur_wr;
      fill_nxt_in = fill_nxt_wr;
      col_in = col_ff;
      sel_in = sel_ff;
      if (accept && req_channel.frame_start) begin
         fill_cur_in = '0;
         fill_nxt_in = '0;
         col_in = '0;
         sel_in = 1'b0;
      end
      if (state_ff == pfsd_pkg::ST_WR_C) begin
         if (last_ff) begin
            fill_cur_in = fill_nxt_wr;
            fill_nxt_in = '0;
            sel_in = !sel_ff;
            col_in = '0;
         end else begin
            col_in = x_p1;
         end
      end
   end

   // quantize, error and shares
   always_comb begin
      logic signed [EW+1:0] vs;
      logic signed [EW-1:0] err;
      logic [10:0] t;
      logic [10:0] prod;
      logic signed [9:0] e;
      logic signed [13:0] e14;
      logic [8:0] idx;
      for (int c = 0; c < pfsd_pkg::CH_N; c++) begin
         err = (dither_ff && cur_vld_ff) ? $signed(cur_q[c*EW +: EW]) : '0;
         vs = $signed({5'b0, pix_ff[c]}) + $signed({{2{err[EW-1]}}, err});
         if (vs < 0) v_calc[c] = '0;
         else if (vs > 13'sd255) v_calc[c] = 8'd255;
         else v_calc[c] = vs[7:0];
         t = 11'(v_calc[c] * m_eff) + 11'd127;
         q_calc[c] = 3'((t + 11'd1 + (t >> 8)) >> 8);
         prod = 11'(q_ff[c] * step);
         e = $signed({2'b0, v_ff[c]}) - $signed({2'b0, prod[7:0]});
         if (!dither_ff) e = '0;
         e14 = 14'(e);
         sh7_c[c] = 12'((e14 * 14'sd7) / 14'sd16);
         sh5_c[c] = 12'((e14 * 14'sd5) / 14'sd16);
         sh3_c[c] = 12'((e14 * 14'sd3) / 14'sd16);
         sh1_c[c] = 12'(e14 / 14'sd16);
      end
      idx = 9'(q_ff[0] * cpc_eff * cpc_eff) + 9'(q_ff[1] * cpc_eff) + 9'(q_ff[2]);
      index_c = idx[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfsd_pkg::ST_IDLE;
         cpc_ff <= pfsd_pkg::CPC_RESET;
         dither_ff <= 1'b1;
         width_ff <= pfsd_pkg::WIDTH_RESET;
         col_ff <= '0;
         sel_ff <= 1'b0;
         fill_cur_ff <= '0;
         fill_nxt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         sel_ff <= sel_in;
         fill_cur_ff <= fill_cur_in;
         fill_nxt_ff <= fill_nxt_in;
         if (state_ff == pfsd_pkg::ST_ERROR && out_load) out_valid_ff <= 1'b1;
         else if (rsp_channel.ready) out_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               pfsd_pkg::CSR_COLORS: cpc_ff <= csr_write_data[pfsd_pkg::CPC_W-1:0];
               pfsd_pkg::CSR_DITHER: dither_ff <= csr_write_data[0];
               pfsd_pkg::CSR_WIDTH:  width_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_vld_ff <= cur_rd_vld;
      nxt_vld_ff <= nxt_rd_vld;
      if (accept) begin
         pix_ff[0] <= req_channel.red_in;
         pix_ff[1] <= req_channel.green_in;
         pix_ff[2] <= req_channel.blue_in;
         x_ff <= x_acc;
         last_ff <= WW'(x_acc) + WW'(1) >= w_eff;
         right_ff <= WW'(x_acc) + WW'(1) < w_eff;
      end
      if (state_ff == pfsd_pkg::ST_QUANT) begin
         v_ff <= v_calc;
         q_ff <= q_calc;
      end
      if (state_ff == pfsd_pkg::ST_ERROR) begin
         sh7_ff <= sh7_c;
         sh5_ff <= sh5_c;
         sh3_ff <= sh3_c;
         sh1_ff <= sh1_c;
         if (out_load) out_index_ff <= index_c;
      end
   end

   // error memories, roles swapped by sel_ff
   always_ff @(posedge clock) begin
      if (sel_ff ? nxt_we : cur_we) bank0[sel_ff ? nxt_wa : cur_wa] <= sel_ff ? nxt_wd : cur_wd;
      bank0_q_ff <= bank0[sel_ff ? nxt_ra : cur_ra];
   end

   always_ff @(posedge clock) begin
      if (sel_ff ? cur_we : nxt_we) bank1[sel_ff ? cur_wa : nxt_wa] <= sel_ff ? cur_wd : nxt_wd;
      bank1_q_ff <= bank1[sel_ff ? cur_ra : nxt_ra];
   end
endmodule
`default_nettype wire

// ===== hdl/pfsd_checker.sv =====
// Port checker for the palette dither block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "palette_floyd_steinberg_dither_assert.svh"
module pfsd_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [pfsd_pkg::INDEX_W-1:0]       rsp_index
);
   `PFSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PFSD_ASSERT_IMPLY(a_index_range, clock, reset, rsp_valid, rsp_index <= 8'd215)
   `PFSD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `PFSD_ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_valid),
                      $past(req_valid && req_ready, 3))
endmodule

bind palette_floyd_steinberg_dither pfsd_checker u_pfsd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_channel.valid),
   .req_ready(req_channel.ready),
   .rsp_valid(rsp_channel.valid),
   .rsp_ready(rsp_channel.ready),
   .rsp_index(rsp_channel.palette_index)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the palette dither block: directed and random pixels with predicted indexes.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int MAXW = 1024;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [pfsd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pfsd_pkg::CSR_W-1:0] csr_write_data = '0;

   pfsd_req_if req_channel();
   pfsd_rsp_if rsp_channel();

   palette_floyd_steinberg_dither dut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_channel.sink),
      .rsp_channel(rsp_channel.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic signed [pfsd_pkg::ERR_W-1:0] cur_err [3][MAXW+1];
   logic signed [pfsd_pkg::ERR_W-1:0] nxt_err [3][MAXW+1];
   int unsigned col;
   int unsigned m_cpc, m_dither, m_width;

   logic [pfsd_pkg::INDEX_W-1:0] index_queue[$];
   int send_idle_pct, recv_idle_pct;
   int errors;
   longint cycles;

   function automatic logic signed [pfsd_pkg::ERR_W-1:0] clamp11(int v);
      if (v > 1023) return 11'sd1023;
      if (v < -1024) return -11'sd1024;
      return v[pfsd_pkg::ERR_W-1:0];
   endfunction

   function automatic void clear_errors();
      for (int c = 0; c < 3; c++)
         for (int i = 0; i <= MAXW; i++) begin
            cur_err[c][i] = '0;
            nxt_err[c][i] = '0;
         end
   endfunction

   function automatic logic [pfsd_pkg::INDEX_W-1:0] predict_index(logic [7:0] r,
                                                                  logic [7:0] g,
                                                                  logic [7:0] b,
                                                                  logic fs);
      int cpc, w, m, stp, x, v, e;
      int q[3];
      logic [7:0] smp[3];
      smp[0] = r; smp[1] = g; smp[2] = b;
      cpc = m_cpc < 2 ? 2 : (m_cpc > 6 ? 6 : m_cpc);
      w = m_width < 1 ? 1 : (m_width > MAXW ? MAXW : m_width);
      m = cpc - 1;
      stp = 255 / m;
      if (fs) begin
         clear_errors();
         col = 0;
      end
      if (col >= w) col = 0;
      x = col;
      for (int c = 0; c < 3; c++) begin
         v = smp[c];
         if (m_dither != 0) begin
            v += cur_err[c][x];
            if (v > 255) v = 255;
            if (v < 0) v = 0;
            q[c] = (v * m + 127) / 255;
            e = v - q[c] * stp;
            if (x + 1 < w) begin
               cur_err[c][x+1] = clamp11(cur_err[c][x+1] + (e * 7) / 16);
               nxt_err[c][x+1] = clamp11(nxt_err[c][x+1] + e / 16);
            end
            nxt_err[c][x] = clamp11(nxt_err[c][x] + (e * 5) / 16);
            if (x > 0) nxt_err[c][x-1] = clamp11(nxt_err[c][x-1] + (e * 3) / 16);
         end else begin
            q[c] = (v * m + 127) / 255;
         end
      end
      if (x + 1 >= w) begin
         for (int c = 0; c < 3; c++)
            for (int i = 0; i <= MAXW; i++) begin
               cur_err[c][i] = nxt_err[c][i];
               nxt_err[c][i] = '0;
            end
         col = 0;
      end else begin
         col = x + 1;
      end
      return 8'((q[0] * cpc * cpc + q[1] * cpc + q[2]) & 255);
   endfunction

   initial begin
      req_channel.valid = 1'b0;
      req_channel.red_in = '0;
      req_channel.green_in = '0;
      req_channel.blue_in = '0;
      req_channel.frame_start = 1'b0;
      rsp_channel.ready = 1'b0;
   end

   // response side
   always @(negedge clock) begin
      if (!reset) rsp_channel.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_channel.valid && rsp_channel.ready) begin
         if (index_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: index %0d", rsp_channel.palette_index);
         end else begin
            if (rsp_channel.palette_index !== index_queue[0]) begin
               errors++;
               if (errors <= 10)
                  $display("index mismatch: expected %0d actual %0d",
                           index_queue[0], rsp_channel.palette_index);
            end
            void'(index_queue.pop_front());
         end
      end
   end

   // valid stays up between back-to-back beats; idling and drain drop it
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_channel.valid <= 1'b0;
         @(negedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.red_in <= r;
      req_channel.green_in <= g;
      req_channel.blue_in <= b;
      req_channel.frame_start <= fs;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
      index_queue.push_back(predict_index(r, g, b, fs));
      @(negedge clock);
   endtask

   task automatic drain();
      req_channel.valid <= 1'b0;
      while (index_queue.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_csr(logic [pfsd_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= pfsd_pkg::CSR_W'(val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == pfsd_pkg::CSR_COLORS) m_cpc = val & 7;
      else if (idx == pfsd_pkg::CSR_DITHER) m_dither = val & 1;
      else if (idx == pfsd_pkg::CSR_WIDTH) m_width = val & 11'h7ff;
   endtask

   task automatic test_directed();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd127, 8'd1, 1'b0);
      send_pixel(8'd254, 8'd43, 8'd170, 1'b0);
      write_csr(pfsd_pkg::CSR_WIDTH, 3);
      write_csr(pfsd_pkg::CSR_COLORS, 2);
      for (int i = 0; i < 7; i++) send_pixel(8'd100, 8'd200, 8'd50, i == 0);
      write_csr(pfsd_pkg::CSR_COLORS, 0);
      write_csr(pfsd_pkg::CSR_DITHER, 0);
      send_pixel(8'd127, 8'd128, 8'd255, 1'b0);
      write_csr(pfsd_pkg::CSR_COLORS, 7);
      write_csr(pfsd_pkg::CSR_WIDTH, 0);
      send_pixel(8'd85, 8'd170, 8'd0, 1'b0);
      write_csr(pfsd_pkg::CSR_DITHER, 1);
      send_pixel(8'd10, 8'd240, 8'd77, 1'b1);
      send_pixel(8'd200, 8'd33, 8'd99, 1'b0);
      write_csr(pfsd_pkg::CSR_WIDTH, 5);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
      send_pixel(8'd4, 8'd5, 8'd6, 1'b0);
      send_pixel(8'd7, 8'd8, 8'd9, 1'b0);
      // width lowered mid-row: column wraps to zero
      write_csr(pfsd_pkg::CSR_WIDTH, 2);
      send_pixel(8'd60, 8'd90, 8'd120, 1'b0);
      write_csr(pfsd_pkg::CSR_WIDTH, 2047);
      send_pixel(8'd33, 8'd66, 8'd99, 1'b1);
   endtask

   task automatic test_random_frames(int n);
      int cnt, sel;
      cnt = 0;
      while (cnt < n) begin
         write_csr(pfsd_pkg::CSR_COLORS, $urandom_range(7));
         write_csr(pfsd_pkg::CSR_DITHER, $urandom_range(99) < 80);
         sel = $urandom_range(9);
         write_csr(pfsd_pkg::CSR_WIDTH, sel == 0 ? 1024 : (sel == 1 ? $urandom_range(2047) :
                                        $urandom_range(1, 12)));
         for (int p = 0; p < 60 && cnt < n; p++) begin
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                       p == 0 ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0));
            cnt++;
         end
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      m_cpc = 6;
      m_dither = 1;
      m_width = 64;
      col = 0;
      clear_errors();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 52;
      test_directed();
      test_random_frames(630);
      send_idle_pct = 52;
      recv_idle_pct = 31;
      test_random_frames(630);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(640);
      drain();
      if (errors == 0 && index_queue.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
